@@ sv/cle_pkg.sv @@
// shared types and constants for the constant lattice evaluator
package cle_pkg;

  localparam int NUM_VREGS_DEF = 1024;
  localparam int REG_W = 10;
  localparam int OP_W = 4;
  localparam int DATA_W = 64;
  localparam int CELL_W = 2 + DATA_W;

  typedef enum logic [2:0] {
    CMD_MARK_BOTTOM  = 3'd0,
    CMD_CONST        = 3'd1,
    CMD_BINOP        = 3'd2,
    CMD_COMPARE      = 3'd3,
    CMD_PHI_SOURCE   = 3'd4,
    CMD_OTHER_RESULT = 3'd5,
    CMD_QUERY        = 3'd6,
    CMD_CLEAR_ALL    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TOP    = 2'd0,
    KIND_CONST  = 2'd1,
    KIND_BOTTOM = 2'd2
  } kind_t;

  localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
  localparam logic [OP_W-1:0] OP_MOD    = 4'd4;
  localparam logic [OP_W-1:0] OP_AND    = 4'd5;
  localparam logic [OP_W-1:0] OP_OR     = 4'd6;
  localparam logic [OP_W-1:0] OP_XOR    = 4'd7;
  localparam logic [OP_W-1:0] OP_LSHIFT = 4'd8;
  localparam logic [OP_W-1:0] OP_RSHIFT = 4'd9;

  localparam logic [OP_W-1:0] CMP_EQ  = 4'd0;
  localparam logic [OP_W-1:0] CMP_NEQ = 4'd1;
  localparam logic [OP_W-1:0] CMP_LT  = 4'd2;
  localparam logic [OP_W-1:0] CMP_GT  = 4'd3;
  localparam logic [OP_W-1:0] CMP_LEQ = 4'd4;
  localparam logic [OP_W-1:0] CMP_GEQ = 4'd5;

  typedef struct packed {
    cmd_t              cmd;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  left_reg;
    logic [REG_W-1:0]  right_reg;
    logic [OP_W-1:0]   op_kind;
    logic [DATA_W-1:0] lit;
    logic              last;
    logic              d_in;
    logic              l_in;
    logic              r_in;
  } item_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } q_out_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } q_ctl_t;

endpackage

@@ sv/cle_ram.sv @@
// generic single write port ram with registered read
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/cle_front.sv @@
// front end: accepts commands, classifies register ranges, two-entry queue
module cle_front import cle_pkg::*; #(
  parameter int NUM_VREGS = NUM_VREGS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               cmd,
  input  logic [REG_W-1:0]         dest_reg,
  input  logic [REG_W-1:0]         left_reg,
  input  logic [REG_W-1:0]         right_reg,
  input  logic [OP_W-1:0]          op_kind,
  input  logic signed [DATA_W-1:0] const_value,
  input  logic                     last_source,
  input  q_ctl_t                   ctl,
  output q_out_t                   q
);

  item_t      cls;
  item_t      slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       accept;

  always_comb begin
    cls.cmd       = cmd_t'(cmd);
    cls.dest_reg  = dest_reg;
    cls.left_reg  = left_reg;
    cls.right_reg = right_reg;
    cls.op_kind   = op_kind;
    cls.lit       = const_value;
    cls.last      = last_source;
    cls.d_in      = 32'(dest_reg) < 32'(NUM_VREGS);
    cls.l_in      = 32'(left_reg) < 32'(NUM_VREGS);
    cls.r_in      = 32'(right_reg) < 32'(NUM_VREGS);
  end

  assign in_stall = (cnt == 2'd2) | ctl.clearing;
  assign accept   = in_valid & ~in_stall;
  assign q.avail  = cnt != 2'd0;
  assign q.item   = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (accept) begin
        wp <= ~wp;
      end
      if (ctl.pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, accept} - {1'b0, ctl.pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wp] <= cls;
    end
  end

endmodule

@@ sv/cle_div.sv @@
// iterative signed divider, one quotient bit per cycle
module cle_div import cle_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quot,
  output logic [DATA_W-1:0] rem
);

  logic              run;
  logic [5:0]        cnt;
  logic [DATA_W-1:0] q_sh;
  logic [DATA_W-1:0] r;
  logic [DATA_W-1:0] mb;
  logic              neg_q;
  logic              neg_r;
  logic [DATA_W-1:0] rsh;
  logic [DATA_W:0]   diff;

  assign rsh  = {r[DATA_W-2:0], q_sh[DATA_W-1]};
  assign diff = {1'b0, rsh} - {1'b0, mb};
  assign quot = neg_q ? (~q_sh + 64'd1) : q_sh;
  assign rem  = neg_r ? (~r + 64'd1) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= '0;
        r     <= '0;
        q_sh  <= dividend[DATA_W-1] ? (~dividend + 64'd1) : dividend;
        mb    <= divisor[DATA_W-1] ? (~divisor + 64'd1) : divisor;
        neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        neg_r <= dividend[DATA_W-1];
      end else if (run) begin
        r    <= diff[DATA_W] ? rsh : diff[DATA_W-1:0];
        q_sh <= {q_sh[DATA_W-2:0], ~diff[DATA_W]};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/cle_back.sv @@
// back end: cell table, transfer rules, phi accumulator and result register
module cle_back import cle_pkg::*; #(
  parameter int NUM_VREGS = NUM_VREGS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  q_out_t                   q,
  output q_ctl_t                   ctl,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     changed,
  output logic [1:0]               cell_state,
  output logic signed [DATA_W-1:0] cell_value
);

  localparam int AW = $clog2(NUM_VREGS);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RR    = 10'b0000000100,
    S_RD    = 10'b0000001000,
    S_CAP   = 10'b0000010000,
    S_EVAL  = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_WR    = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t            state;
  item_t             cur;
  kind_t             lk, rk, dk, nk, mk, mk_new;
  logic [DATA_W-1:0] lv, rv, dv, nv, mc, mc_new;
  logic              wr_en;
  logic [AW-1:0]     clr_cnt;
  logic [1:0]        mcnt;
  logic [DATA_W-1:0] prod, acc;
  logic [31:0]       mul_a, mul_b;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;
  kind_t             rd_kind;
  logic [DATA_W-1:0] rd_val;
  logic              out_free;
  logic              both_const, any_bottom, is_divmod, div_start, div_done;
  logic [DATA_W-1:0] alu_res, quot, rem;
  logic              cmp_res;

  cle_ram #(.WIDTH(CELL_W), .DEPTH(NUM_VREGS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  cle_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(lv), .divisor(rv),
    .done(div_done), .quot(quot), .rem(rem)
  );

  assign rd_kind      = kind_t'(rdata[CELL_W-1 -: 2]);
  assign rd_val       = rdata[DATA_W-1:0];
  assign out_free     = ~out_valid | ~out_stall;
  assign ctl.pop      = (state == S_IDLE) & q.avail;
  assign ctl.clearing = state == S_CLEAR;
  assign both_const   = (lk == KIND_CONST) & (rk == KIND_CONST);
  assign any_bottom   = (lk == KIND_BOTTOM) | (rk == KIND_BOTTOM);
  assign is_divmod    = (cur.op_kind == OP_DIV) | (cur.op_kind == OP_MOD);
  assign div_start    = (state == S_EVAL) & (cur.cmd == CMD_BINOP) & ~any_bottom &
                        both_const & is_divmod & (rv != '0);

  always_comb begin
    unique case (state)
      S_IDLE:  raddr = AW'(q.item.left_reg);
      S_RR:    raddr = AW'(cur.right_reg);
      S_RD:    raddr = AW'(cur.dest_reg);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(cur.dest_reg);
    wdata = {nk, (nk == KIND_CONST) ? nv : {DATA_W{1'b0}}};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (state == S_WR) begin
      we = wr_en & cur.d_in & out_free;
    end
  end

  always_comb begin
    case (cur.op_kind)
      OP_ADD:    alu_res = lv + rv;
      OP_SUB:    alu_res = lv - rv;
      OP_AND:    alu_res = lv & rv;
      OP_OR:     alu_res = lv | rv;
      OP_XOR:    alu_res = lv ^ rv;
      OP_LSHIFT: alu_res = lv << rv[5:0];
      OP_RSHIFT: alu_res = $signed(lv) >>> rv[5:0];
      default:   alu_res = '0;
    endcase
    case (cur.op_kind)
      CMP_EQ:  cmp_res = lv == rv;
      CMP_NEQ: cmp_res = lv != rv;
      CMP_LT:  cmp_res = $signed(lv) < $signed(rv);
      CMP_GT:  cmp_res = $signed(rv) < $signed(lv);
      CMP_LEQ: cmp_res = !($signed(rv) < $signed(lv));
      CMP_GEQ: cmp_res = !($signed(lv) < $signed(rv));
      default: cmp_res = 1'b0;
    endcase
  end

  always_comb begin
    mk_new = mk;
    mc_new = mc;
    if (lk == KIND_BOTTOM) begin
      mk_new = KIND_BOTTOM;
    end else if (lk == KIND_CONST) begin
      if (mk == KIND_TOP) begin
        mk_new = KIND_CONST;
        mc_new = lv;
      end else if (mk == KIND_CONST && mc != lv) begin
        mk_new = KIND_BOTTOM;
      end
    end
  end

  always_comb begin
    mul_a = (mcnt == 2'd2) ? lv[63:32] : lv[31:0];
    mul_b = (mcnt == 2'd1) ? rv[63:32] : rv[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      mk        <= KIND_TOP;
      mc        <= '0;
      mcnt      <= '0;
    end else begin
      if (out_valid & ~out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(NUM_VREGS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q.avail) begin
            cur   <= q.item;
            state <= S_RR;
          end
        end
        S_RR: begin
          lk    <= cur.l_in ? rd_kind : KIND_BOTTOM;
          lv    <= cur.l_in ? rd_val : '0;
          state <= S_RD;
        end
        S_RD: begin
          rk    <= cur.r_in ? rd_kind : KIND_BOTTOM;
          rv    <= cur.r_in ? rd_val : '0;
          state <= S_CAP;
        end
        S_CAP: begin
          dk    <= cur.d_in ? rd_kind : KIND_BOTTOM;
          dv    <= cur.d_in ? rd_val : '0;
          state <= S_EVAL;
        end
        S_EVAL: begin
          nk    <= dk;
          nv    <= dv;
          wr_en <= 1'b0;
          state <= S_WR;
          unique case (cur.cmd)
            CMD_MARK_BOTTOM: begin
              nk    <= KIND_BOTTOM;
              nv    <= '0;
              wr_en <= 1'b1;
            end
            CMD_CONST: begin
              nk    <= KIND_CONST;
              nv    <= cur.lit;
              wr_en <= 1'b1;
            end
            CMD_BINOP, CMD_COMPARE: begin
              if (any_bottom) begin
                nk    <= KIND_BOTTOM;
                nv    <= '0;
                wr_en <= 1'b1;
              end else if (both_const) begin
                if (cur.cmd == CMD_COMPARE) begin
                  nk    <= KIND_CONST;
                  nv    <= {63'd0, cmp_res};
                  wr_en <= 1'b1;
                end else if (cur.op_kind == OP_MUL) begin
                  mcnt  <= '0;
                  state <= S_MUL;
                end else if (is_divmod) begin
                  if (rv != '0) begin
                    state <= S_DIV;
                  end else if (cur.op_kind == OP_MOD) begin
                    nk    <= KIND_CONST;
                    nv    <= '0;
                    wr_en <= 1'b1;
                  end
                end else begin
                  nk    <= KIND_CONST;
                  nv    <= alu_res;
                  wr_en <= 1'b1;
                end
              end
            end
            CMD_PHI_SOURCE: begin
              if (cur.last) begin
                nk    <= mk_new;
                nv    <= mc_new;
                wr_en <= 1'b1;
                mk    <= KIND_TOP;
                mc    <= '0;
              end else begin
                mk    <= mk_new;
                mc    <= mc_new;
                state <= S_IDLE;
              end
            end
            CMD_OTHER_RESULT: begin
              if (dk == KIND_TOP) begin
                nk    <= KIND_BOTTOM;
                nv    <= '0;
                wr_en <= 1'b1;
              end
            end
            CMD_QUERY: begin
              nk <= lk;
              nv <= lv;
            end
            CMD_CLEAR_ALL: begin
              mk      <= KIND_TOP;
              mc      <= '0;
              clr_cnt <= '0;
              state   <= S_CLEAR;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_MUL: begin
          mcnt <= mcnt + 2'd1;
          prod <= 64'(mul_a) * 64'(mul_b);
          case (mcnt)
            2'd1:    acc <= prod;
            2'd2:    acc <= acc + {prod[31:0], 32'd0};
            2'd3: begin
              nk    <= KIND_CONST;
              nv    <= acc + {prod[31:0], 32'd0};
              wr_en <= 1'b1;
              state <= S_WR;
            end
            default: acc <= '0;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            nk    <= KIND_CONST;
            nv    <= (cur.op_kind == OP_DIV) ? quot : rem;
            wr_en <= 1'b1;
            state <= S_WR;
          end
        end
        S_WR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            changed   <= wr_en & cur.d_in &
                         ((dk != nk) | ((nk == KIND_CONST) & (dv != nv)));
            if (wr_en & ~cur.d_in) begin
              cell_state <= KIND_BOTTOM;
              cell_value <= '0;
            end else begin
              cell_state <= nk;
              cell_value <= (nk == KIND_CONST) ? nv : '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/constant_lattice_evaluator.sv @@
// top level of the constant lattice evaluator
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | cmd dest_reg left_reg right_reg op_kind
//           |                      | const_value last_source
//  output   | out_valid / out_stall| changed cell_state cell_value
//
// a command is handled in steps: one table read port serves left, right and dest in turn,
// then the rule is evaluated and, for commands that update it, the dest cell written
// mul uses a shared 32x32 multiplier, div and mod use the bit-serial divider
// reset and clear_all sweep every cell of the table with in_stall high
// two commands queue at the input while the back end works or the output is stalled
module constant_lattice_evaluator import cle_pkg::*; #(
  parameter int NUM_VREGS = NUM_VREGS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               cmd,
  input  logic [REG_W-1:0]         dest_reg,
  input  logic [REG_W-1:0]         left_reg,
  input  logic [REG_W-1:0]         right_reg,
  input  logic [OP_W-1:0]          op_kind,
  input  logic signed [DATA_W-1:0] const_value,
  input  logic                     last_source,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     changed,
  output logic [1:0]               cell_state,
  output logic signed [DATA_W-1:0] cell_value
);

  q_out_t q;
  q_ctl_t ctl;

  cle_front #(.NUM_VREGS(NUM_VREGS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .dest_reg(dest_reg), .left_reg(left_reg), .right_reg(right_reg),
    .op_kind(op_kind), .const_value(const_value), .last_source(last_source),
    .ctl(ctl), .q(q)
  );

  cle_back #(.NUM_VREGS(NUM_VREGS)) u_back (
    .clk(clk), .rst(rst), .q(q), .ctl(ctl), .out_valid(out_valid),
    .out_stall(out_stall), .changed(changed), .cell_state(cell_state),
    .cell_value(cell_value)
  );

endmodule

@@ sv/cle_checker.sv @@
// port-level checker for the constant lattice evaluator, bound to the top level
module cle_checker import cle_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     changed,
  input logic [1:0]               cell_state,
  input logic signed [DATA_W-1:0] cell_value
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_sweep_stall: assert property (@(posedge clk) $fell(rst) |-> in_stall)
    else $error("input taken during table sweep after reset");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_state != KIND_CONST |-> cell_value == '0)
    else $error("nonzero value on a non-constant cell");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_value) &&
      $stable(cell_state) && $stable(changed))
    else $error("stalled result changed");

  a_no_state3: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_state != 2'd3)
    else $error("invalid cell state code on output");

endmodule

bind constant_lattice_evaluator cle_checker u_cle_checker (.*);

@@ sim/constant_lattice_evaluator_checker.sv @@
// checker for the constant lattice evaluator: lattice table predictor and result compare
module constant_lattice_evaluator_checker import cle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [9:0]  dest_reg,
  input  logic [9:0]  left_reg,
  input  logic [9:0]  right_reg,
  input  logic [3:0]  op_kind,
  input  logic [63:0] const_value,
  input  logic        last_source,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        changed,
  input  logic [1:0]  cell_state,
  input  logic [63:0] cell_value,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        chg;
    kind_t       kind;
    logic [63:0] value;
  } cell_result_t;

  kind_t        lat_kind [1024];
  logic [63:0]  lat_value [1024];
  kind_t        phi_kind;
  logic [63:0]  phi_value;
  cell_result_t expected_cells [$];

  function automatic void clear_lattice();
    for (int i = 0; i < 1024; i++) begin
      lat_kind[i] = KIND_TOP;
      lat_value[i] = '0;
    end
    phi_kind = KIND_TOP;
    phi_value = '0;
  endfunction

  function automatic logic write_cell(logic [9:0] idx, kind_t k, logic [63:0] v);
    logic chg;
    if (k != KIND_CONST) v = '0;
    chg = (lat_kind[idx] != k) || (k == KIND_CONST && lat_value[idx] != v);
    lat_kind[idx] = k;
    lat_value[idx] = v;
    return chg;
  endfunction

  // returns 0 when the destination is to be kept
  function automatic logic eval_binop(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                                      output logic [63:0] res);
    logic signed [63:0] sa, sb;
    sa = a;
    sb = b;
    res = '0;
    case (op)
      OP_ADD:    res = a + b;
      OP_SUB:    res = a - b;
      OP_MUL:    res = a * b;
      OP_DIV: begin
        if (b == 0) return 1'b0;
        if (a == MIN64 && b == '1) res = MIN64;
        else res = sa / sb;
      end
      OP_MOD: begin
        if (b == 0 || (a == MIN64 && b == '1)) res = '0;
        else res = sa % sb;
      end
      OP_AND:    res = a & b;
      OP_OR:     res = a | b;
      OP_XOR:    res = a ^ b;
      OP_LSHIFT: res = a << b[5:0];
      OP_RSHIFT: res = sa >>> b[5:0];
      default:   res = '0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [63:0] eval_compare(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    logic r;
    case (op)
      CMP_EQ:  r = a == b;
      CMP_NEQ: r = a != b;
      CMP_LT:  r = $signed(a) < $signed(b);
      CMP_GT:  r = $signed(a) > $signed(b);
      CMP_LEQ: r = $signed(a) <= $signed(b);
      CMP_GEQ: r = $signed(a) >= $signed(b);
      default: r = 1'b0;
    endcase
    return {63'd0, r};
  endfunction

  function automatic void apply_command();
    kind_t        lk, rk;
    logic [63:0]  lv, rv, res;
    logic         chg;
    logic [9:0]   shown;
    cell_result_t e;
    lk = lat_kind[left_reg];
    rk = lat_kind[right_reg];
    lv = lat_value[left_reg];
    rv = lat_value[right_reg];
    chg = 1'b0;
    shown = dest_reg;
    case (cmd_t'(cmd))
      CMD_MARK_BOTTOM: chg = write_cell(dest_reg, KIND_BOTTOM, '0);
      CMD_CONST:       chg = write_cell(dest_reg, KIND_CONST, const_value);
      CMD_BINOP, CMD_COMPARE: begin
        if (lk == KIND_BOTTOM || rk == KIND_BOTTOM)
          chg = write_cell(dest_reg, KIND_BOTTOM, '0);
        else if (lk == KIND_CONST && rk == KIND_CONST) begin
          if (cmd_t'(cmd) == CMD_COMPARE)
            chg = write_cell(dest_reg, KIND_CONST, eval_compare(op_kind, lv, rv));
          else if (eval_binop(op_kind, lv, rv, res))
            chg = write_cell(dest_reg, KIND_CONST, res);
        end
      end
      CMD_PHI_SOURCE: begin
        if (lk == KIND_BOTTOM) phi_kind = KIND_BOTTOM;
        else if (lk == KIND_CONST) begin
          if (phi_kind == KIND_TOP) begin
            phi_kind = KIND_CONST;
            phi_value = lv;
          end else if (phi_kind == KIND_CONST && phi_value != lv) begin
            phi_kind = KIND_BOTTOM;
          end
        end
        if (!last_source) return;
        chg = write_cell(dest_reg, phi_kind, phi_value);
        phi_kind = KIND_TOP;
        phi_value = '0;
      end
      CMD_OTHER_RESULT: if (lat_kind[dest_reg] == KIND_TOP)
        chg = write_cell(dest_reg, KIND_BOTTOM, '0);
      CMD_QUERY: shown = left_reg;
      default: begin
        clear_lattice();
        return;
      end
    endcase
    e.chg = chg;
    e.kind = lat_kind[shown];
    e.value = lat_value[shown];
    expected_cells.push_back(e);
  endfunction

  function automatic void report(string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endfunction

  initial begin
    clear_lattice();
    errors = 0;
    checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cell_result_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_cells.size() == 0)
          report($sformatf("result with nothing expected: changed %0b state %0d value %h",
                           changed, cell_state, cell_value));
        else begin
          e = expected_cells.pop_front();
          if (changed !== e.chg || cell_state !== e.kind || cell_value !== e.value)
            report($sformatf("expected changed %0b state %0d value %h, got %0b %0d %h",
                             e.chg, e.kind, e.value, changed, cell_state, cell_value));
        end
      end
      if (in_valid && !in_stall) apply_command();
      pending = expected_cells.size();
    end
  end

endmodule

@@ sim/constant_lattice_evaluator_test.sv @@
// testbench top for the constant lattice evaluator: stimulus, stall control and verdict
module constant_lattice_evaluator_test;
  import cle_pkg::*;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  cmd;
  logic [9:0]  dest_reg, left_reg, right_reg;
  logic [3:0]  op_kind;
  logic [63:0] const_value;
  logic        last_source;
  logic        out_valid;
  logic        out_stall;
  logic        changed;
  logic [1:0]  cell_state;
  logic [63:0] cell_value;
  int          errors, pending, checked;
  int          idle_pct, stall_pct, sent, quiet;
  logic        hold_req;

  constant_lattice_evaluator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .dest_reg(dest_reg), .left_reg(left_reg), .right_reg(right_reg),
    .op_kind(op_kind), .const_value(const_value), .last_source(last_source),
    .out_valid(out_valid), .out_stall(out_stall),
    .changed(changed), .cell_state(cell_state), .cell_value(cell_value)
  );

  constant_lattice_evaluator_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .dest_reg(dest_reg), .left_reg(left_reg), .right_reg(right_reg),
    .op_kind(op_kind), .const_value(const_value), .last_source(last_source),
    .out_valid(out_valid), .out_stall(out_stall),
    .changed(changed), .cell_state(cell_state), .cell_value(cell_value),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send(input cmd_t c, input logic [9:0] d, input logic [9:0] l,
                      input logic [9:0] r, input logic [3:0] op, input logic [63:0] v,
                      input logic last);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    dest_reg <= d;
    left_reg <= l;
    right_reg <= r;
    op_kind <= op;
    const_value <= v;
    last_source <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_reg();
    if ($urandom_range(99) < 85) return 10'($urandom_range(7));
    return 10'($urandom);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return MIN64;
      3: return MAX64;
      4: return 64'($urandom_range(70));
      5: return -64'($urandom_range(70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    int sel, n;
    sel = $urandom_range(99);
    if (sel < 25)
      send(CMD_CONST, pick_reg(), 10'($urandom), 10'($urandom), 4'($urandom), pick_value(),
           1'($urandom));
    else if (sel < 50)
      send(CMD_BINOP, pick_reg(), pick_reg(), pick_reg(), 4'($urandom_range(10)),
           {$urandom, $urandom}, 1'($urandom));
    else if (sel < 60)
      send(CMD_COMPARE, pick_reg(), pick_reg(), pick_reg(), 4'($urandom_range(7)),
           {$urandom, $urandom}, 1'($urandom));
    else if (sel < 75) begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
        send(CMD_PHI_SOURCE, pick_reg(), pick_reg(), 10'($urandom), 4'($urandom),
             {$urandom, $urandom}, i == n - 1);
        if ($urandom_range(9) == 0)
          send(CMD_QUERY, pick_reg(), pick_reg(), pick_reg(), 4'($urandom), '0, 1'b0);
      end
    end
    else if (sel < 81)
      send(CMD_MARK_BOTTOM, pick_reg(), pick_reg(), pick_reg(), 4'($urandom), '0,
           1'($urandom));
    else if (sel < 88)
      send(CMD_OTHER_RESULT, pick_reg(), pick_reg(), pick_reg(), 4'($urandom), '0,
           1'($urandom));
    else if (sel < 99)
      send(CMD_QUERY, pick_reg(), pick_reg(), pick_reg(), 4'($urandom), '0, 1'($urandom));
    else
      send(CMD_CLEAR_ALL, pick_reg(), pick_reg(), pick_reg(), 4'($urandom), '0, 1'b0);
  endtask

  // receiver stall control, with one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("constant_lattice_evaluator verification failed");
        $finish;
      end
    end
  end

  initial begin
    int idle_mix [4] = '{0, 51, 0, 23};
    int stall_mix [4] = '{0, 0, 51, 23};
    sent = 0;
    hold_req = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= '0;
    dest_reg <= '0;
    left_reg <= '0;
    right_reg <= '0;
    op_kind <= '0;
    const_value <= '0;
    last_source <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send(CMD_BINOP, 10'd9, 10'd1, 10'd2, OP_ADD, '0, 1'b0);
    send(CMD_CONST, 10'd1, '0, '0, '0, MIN64, 1'b0);
    send(CMD_CONST, 10'd2, '0, '0, '0, '1, 1'b0);
    send(CMD_CONST, 10'd3, '0, '0, '0, '0, 1'b0);
    send(CMD_CONST, 10'd1023, 10'd1023, 10'd1023, 4'hf, MAX64, 1'b1);
    send(CMD_BINOP, 10'd5, 10'd1, 10'd2, OP_DIV, '0, 1'b0);
    send(CMD_BINOP, 10'd6, 10'd1, 10'd2, OP_MOD, '0, 1'b0);
    send(CMD_BINOP, 10'd5, 10'd1023, 10'd3, OP_DIV, '0, 1'b0);
    send(CMD_BINOP, 10'd6, 10'd1023, 10'd3, OP_MOD, '0, 1'b0);
    send(CMD_BINOP, 10'd7, 10'd1023, 10'd2, OP_LSHIFT, '0, 1'b0);
    send(CMD_BINOP, 10'd7, 10'd1, 10'd2, OP_RSHIFT, '0, 1'b0);
    send(CMD_BINOP, 10'd8, 10'd1023, 10'd1023, OP_MUL, '0, 1'b0);
    send(CMD_BINOP, 10'd8, 10'd1, 10'd2, 4'd12, '0, 1'b0);
    for (int op = 0; op < 7; op++)
      send(CMD_COMPARE, 10'd10 + 10'(op), 10'd1, 10'd1023, 4'(op), '0, 1'b0);
    send(CMD_MARK_BOTTOM, 10'd4, '0, '0, '0, '0, 1'b0);
    send(CMD_BINOP, 10'd9, 10'd4, 10'd1, OP_SUB, '0, 1'b0);
    send(CMD_PHI_SOURCE, 10'd20, 10'd1, '0, '0, '0, 1'b0);
    send(CMD_QUERY, '0, 10'd1, '0, '0, '0, 1'b0);
    send(CMD_PHI_SOURCE, 10'd20, 10'd2, '0, '0, '0, 1'b1);
    send(CMD_OTHER_RESULT, 10'd21, '0, '0, '0, '0, 1'b0);
    send(CMD_CLEAR_ALL, '0, '0, '0, '0, '0, 1'b0);
    send(CMD_QUERY, '0, 10'd1, '0, '0, '0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      for (int i = 0; i < 135; i++) begin
        if (ph == 0 && i == 60) hold_req = 1'b1;
        if (i == 100) settle();
        send_random();
      end
    end

    settle();
    repeat (200) @(posedge clk);
    $display("%0d commands sent, %0d results checked over four idle and stall mixes,",
             sent, checked);
    $display("including a long output hold, drain pauses, phi runs and table clears");
    if (errors == 0) begin
      $display("constant_lattice_evaluator verification clean");
    end else begin
      $display("constant_lattice_evaluator verification failed");
    end
    $finish;
  end

endmodule
